### design/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Clocked check, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset.
`define ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NR(label, clk, prop, msg)
`endif

`endif

### design/xyrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package xyrt_pkg;

  // register map
  localparam logic [2:0] REG_X0   = 3'd0;
  localparam logic [2:0] REG_Y0   = 3'd1;
  localparam logic [2:0] REG_X1   = 3'd2;
  localparam logic [2:0] REG_Y1   = 3'd3;
  localparam logic [2:0] REG_FLEN = 3'd4;

  localparam logic [15:0] RST_X0   = 16'd16384;
  localparam logic [15:0] RST_Y0   = 16'd16384;
  localparam logic [15:0] RST_X1   = 16'd49151;
  localparam logic [15:0] RST_Y1   = 16'd49151;
  localparam logic [15:0] RST_FLEN = 16'd1024;

  // segment length is frame_length / 4, fits 14 bits
  localparam int SEG_W     = 14;
  localparam int SEG_COUNT = 4;

  // x / 5 == (x * 52429) >> 18 for any 16-bit x
  localparam int          PROD_W     = 30;
  localparam logic [15:0] DIV5_MULT  = 16'd52429;
  localparam int          DIV5_SHIFT = 18;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIV_FIN,
    ST_SEG,
    ST_PREP,
    ST_MUL,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

### design/xy_rectangle_trace_gen_top.sv
// XY rectangle trace generator.
// Input channel (in_valid/in_ready, restart): each request yields exactly one
// XY sample on the output channel (out_valid/out_ready, x_out, y_out,
// frame_last). restart=1 recomputes the ramp steps and emits sample 0 of a
// new frame; restart=0 emits the current sample and advances one tick.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
// write it only while no request is in flight. Unknown indexes are dropped.
// Flow: one request at a time through a single shared adder. A plain tick
// runs the segment search, then setup, the multiply over the bits of the ramp
// position (up to 14 bits) and the output load; the next request is taken
// once the block is back in idle after the result loads. A restart first adds
// two restoring divisions of a 16+FRAC_BITS-bit dividend, one per axis.
// in_ready rises again as soon as a result sits in the output register, so
// the next request is taken while that result waits. If the receiver stalls,
// the next result waits in its final state until the register is free.
// Reset: corners and frame length return to their defaults, steps clear to
// zero (flat ramps until the first restart), sample index returns to 0.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module xy_rectangle_trace_gen_top
  import xyrt_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        restart,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      x_out,
  output logic [15:0]      y_out,
  output logic             frame_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int NW = 16 + FRAC_BITS;   // dividend / quotient width
  localparam int SW = NW + 1;           // signed step width
  // accumulator and shared adder width: a stale step times a full ramp length
  localparam int AW = FRAC_BITS + 32;
  localparam int CW = $clog2(NW + 1);

  state_t state, state_next;

  logic [15:0] corner_x0, corner_y0, corner_x1, corner_y1, frame_length;

  logic [SEG_W-1:0]  seg, dwell_r, line_r;
  logic [PROD_W-1:0] dwell_prod;
  logic [SEG_W-1:0]  dwell_c;

  logic [SW-1:0] step_x, step_y;
  logic          div_y, div_neg;
  logic [CW-1:0] div_cnt;
  logic [NW-1:0] div_num, div_quo;
  logic [SEG_W-1:0] div_rem;
  logic [SEG_W:0]   rem_sh;

  logic [15:0] from_c, to_c, mag_c;
  logic [16:0] diff_c;

  logic [15:0] sample_index, seg_rem;
  logic [2:0]  seg_num;
  logic [AW-1:0] acc, mcand;
  logic [SEG_W-1:0] k_reg;
  logic          dir_pos;

  logic [AW-1:0] alu_a, alu_b, alu_sum;
  logic          alu_cin;

  logic [15:0] ramp_c, x_c, y_c;
  logic        last_c, out_load;
  logic [SW-1:0] step_sel;
  logic [15:0]   start_sel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_x0    <= RST_X0;
      corner_y0    <= RST_Y0;
      corner_x1    <= RST_X1;
      corner_y1    <= RST_Y1;
      frame_length <= RST_FLEN;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_X0:   corner_x0    <= cfg_data;
        REG_Y0:   corner_y0    <= cfg_data;
        REG_X1:   corner_x1    <= cfg_data;
        REG_Y1:   corner_y1    <= cfg_data;
        REG_FLEN: frame_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // segment geometry; settles well before any request can use it
  assign seg        = frame_length[15:2];
  assign dwell_prod = PROD_W'(seg) * PROD_W'(DIV5_MULT);
  assign dwell_c    = SEG_W'(dwell_prod >> DIV5_SHIFT);

  always_ff @(posedge clk) begin
    dwell_r <= dwell_c;
    line_r  <= seg - dwell_c;
  end

  // divider operand selection for the axis being loaded
  always_comb begin
    if (state == ST_IDLE) begin
      from_c = corner_x0;
      to_c   = corner_x1;
    end else begin
      from_c = corner_y0;
      to_c   = corner_y1;
    end
    diff_c = {1'b0, to_c} - {1'b0, from_c};
    mag_c  = diff_c[16] ? 16'(-diff_c) : diff_c[15:0];
  end

  assign rem_sh = {div_rem, div_num[NW-1]};

  // the one shared adder
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_cin = 1'b0;
    case (state)
      ST_DIV: begin
        alu_a   = AW'(rem_sh);
        alu_b   = ~AW'(line_r);
        alu_cin = 1'b1;
      end
      ST_DIV_FIN: begin
        alu_a   = div_neg ? ~AW'(div_quo) : AW'(div_quo);
        alu_cin = div_neg;
      end
      ST_SEG: begin
        alu_a   = AW'(seg_rem);
        alu_b   = ~AW'(seg);
        alu_cin = 1'b1;
      end
      ST_PREP: begin
        alu_a   = AW'(seg_rem);
        alu_b   = ~AW'(dwell_r);
        alu_cin = 1'b1;
      end
      ST_MUL: begin
        alu_a   = acc;
        alu_b   = dir_pos ? mcand : ~mcand;
        alu_cin = !dir_pos;
      end
      default: ;
    endcase
    alu_sum = alu_a + alu_b + AW'(alu_cin);
  end

  always_comb begin
    case (seg_num)
      3'd0: begin
        start_sel = corner_x0;
        step_sel  = step_x;
      end
      3'd1: begin
        start_sel = corner_y0;
        step_sel  = step_y;
      end
      3'd2: begin
        start_sel = corner_x1;
        step_sel  = step_x;
      end
      default: begin
        start_sel = corner_y1;
        step_sel  = step_y;
      end
    endcase
  end

  // saturate the ramp position to a DAC code
  always_comb begin
    if (acc[AW-1])
      ramp_c = '0;
    else if (|acc[AW-2:FRAC_BITS+16])
      ramp_c = 16'hFFFF;
    else
      ramp_c = acc[FRAC_BITS+15:FRAC_BITS];
  end

  always_comb begin
    case (seg_num)
      3'd0: begin
        x_c = ramp_c;
        y_c = corner_y0;
      end
      3'd1: begin
        x_c = corner_x1;
        y_c = ramp_c;
      end
      3'd2: begin
        x_c = ramp_c;
        y_c = corner_y1;
      end
      3'd3: begin
        x_c = corner_x0;
        y_c = ramp_c;
      end
      default: begin
        x_c = corner_x0;
        y_c = corner_y0;
      end
    endcase
  end

  assign last_c   = (frame_length <= 16'd1) ||
                    ({1'b0, sample_index} + 17'd1 >= {1'b0, frame_length});
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    in_ready   = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = restart ? ST_DIV : ST_SEG;
      end
      ST_DIV: begin
        if (div_cnt == CW'(1)) state_next = ST_DIV_FIN;
      end
      ST_DIV_FIN: begin
        state_next = div_y ? ST_SEG : ST_DIV;
      end
      ST_SEG: begin
        if (seg == '0 || seg_num == 3'(SEG_COUNT) || alu_sum[AW-1])
          state_next = ST_PREP;
      end
      ST_PREP: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        if (k_reg == '0) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      step_x       <= '0;
      step_y       <= '0;
      seg_num      <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_load)                    out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            seg_num <= '0;
            if (restart) begin
              sample_index <= '0;
              div_y        <= 1'b0;
              div_neg      <= diff_c[16];
              div_num      <= {mag_c, {FRAC_BITS{1'b0}}};
              div_rem      <= '0;
              div_quo      <= '0;
              div_cnt      <= CW'(NW);
            end else begin
              seg_rem <= sample_index;
            end
          end
        end
        ST_DIV: begin
          div_num <= {div_num[NW-2:0], 1'b0};
          div_cnt <= div_cnt - CW'(1);
          if (!alu_sum[AW-1]) begin
            div_rem <= alu_sum[SEG_W-1:0];
            div_quo <= {div_quo[NW-2:0], 1'b1};
          end else begin
            div_rem <= rem_sh[SEG_W-1:0];
            div_quo <= {div_quo[NW-2:0], 1'b0};
          end
        end
        ST_DIV_FIN: begin
          // zero line length means a flat ramp
          if (div_y) step_y <= (line_r == '0) ? '0 : alu_sum[SW-1:0];
          else       step_x <= (line_r == '0) ? '0 : alu_sum[SW-1:0];
          if (!div_y) begin
            div_y   <= 1'b1;
            div_neg <= diff_c[16];
            div_num <= {mag_c, {FRAC_BITS{1'b0}}};
            div_rem <= '0;
            div_quo <= '0;
            div_cnt <= CW'(NW);
          end else begin
            seg_rem <= sample_index;
          end
        end
        ST_SEG: begin
          if (seg == '0 || seg_num == 3'(SEG_COUNT)) begin
            seg_num <= 3'(SEG_COUNT);
            seg_rem <= '0;
          end else if (!alu_sum[AW-1]) begin
            seg_rem <= alu_sum[15:0];
            seg_num <= seg_num + 3'd1;
          end
        end
        ST_PREP: begin
          acc     <= AW'({start_sel, {FRAC_BITS{1'b0}}});
          mcand   <= {{(AW-SW){step_sel[SW-1]}}, step_sel};
          dir_pos <= (seg_num < 3'd2);
          // dwelling or remainder: position stays at the corner
          if (seg_num == 3'(SEG_COUNT) || alu_sum[AW-1]) k_reg <= '0;
          else                                           k_reg <= alu_sum[SEG_W-1:0];
        end
        ST_MUL: begin
          if (k_reg != '0) begin
            if (k_reg[0]) acc <= alu_sum;
            mcand <= {mcand[AW-2:0], 1'b0};
            k_reg <= {1'b0, k_reg[SEG_W-1:1]};
          end
        end
        ST_DONE: begin
          if (out_load) begin
            x_out        <= x_c;
            y_out        <= y_c;
            frame_last   <= last_c;
            sample_index <= last_c ? '0 : sample_index + 16'd1;
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_CLK(a_busy_after_accept, clk, rst, (in_valid && in_ready) |=> !in_ready,
              "in_ready high right after a request was taken")
  `ASSERT_CLK(a_wrap_on_last, clk, rst, (out_load && last_c) |=> (sample_index == '0),
              "sample index did not wrap after the last sample")
  `ASSERT_CLK(a_seg_range, clk, rst, (state == ST_PREP) |-> (seg_num <= 3'(SEG_COUNT)),
              "segment number out of range")
  `ASSERT_CLK(a_flat_step, clk, rst,
              (state == ST_DIV_FIN && !div_y && line_r == '0) |=> (step_x == '0),
              "step not zero for zero line length")

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import xyrt_pkg::*;

  localparam int FRAC_BITS = 16;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic        last;
  } trace_sample_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        restart = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] x_out;
  logic [15:0] y_out;
  logic        frame_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // trace state mirrored from the block
  int unsigned corner_x0 = RST_X0;
  int unsigned corner_y0 = RST_Y0;
  int unsigned corner_x1 = RST_X1;
  int unsigned corner_y1 = RST_Y1;
  int unsigned frame_len = RST_FLEN;
  int unsigned sample_pos = 0;
  longint      slope_x = 0;
  longint      slope_y = 0;

  trace_sample_t pending_samples[$];
  int            mismatches = 0;
  int            hold_left = 0;
  bit            steady = 1'b0;

  xy_rectangle_trace_gen_top #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .restart   (restart),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .x_out     (x_out),
    .y_out     (y_out),
    .frame_last(frame_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint ramp_slope(int unsigned from, int unsigned to,
                                        int unsigned len);
    longint diff;
    diff = longint'(to) - longint'(from);
    if (len == 0) return 0;
    return (diff * (longint'(1) << FRAC_BITS)) / longint'(len);
  endfunction

  function automatic logic [15:0] ramp_point(int unsigned start, longint slope,
                                             bit down, int unsigned k);
    longint acc;
    longint q;
    acc = longint'(start) * (longint'(1) << FRAC_BITS);
    if (down) acc -= slope * longint'(k);
    else acc += slope * longint'(k);
    if (acc < 0) return 16'd0;
    q = acc >>> FRAC_BITS;
    if (q > 65535) return 16'hFFFF;
    return q[15:0];
  endfunction

  function automatic trace_sample_t next_trace_sample(bit rs);
    int unsigned   seg;
    int unsigned   dwell;
    int unsigned   len;
    int unsigned   s;
    int unsigned   ph;
    int unsigned   k;
    int unsigned   xv;
    int unsigned   yv;
    bit            dwelling;
    bit            last;
    trace_sample_t r;
    seg   = frame_len >> 2;
    dwell = seg / 5;
    len   = seg - dwell;
    if (rs) begin
      slope_x    = ramp_slope(corner_x0, corner_x1, len);
      slope_y    = ramp_slope(corner_y0, corner_y1, len);
      sample_pos = 0;
    end
    // remainder samples and seg == 0 hold at the first corner
    xv = corner_x0;
    yv = corner_y0;
    if (seg != 0) begin
      s = sample_pos / seg;
      if (s < SEG_COUNT) begin
        ph       = sample_pos - s * seg;
        dwelling = ph < dwell;
        k        = dwelling ? 0 : ph - dwell;
        case (s)
          0: begin
            if (!dwelling) xv = ramp_point(corner_x0, slope_x, 1'b0, k);
          end
          1: begin
            xv = corner_x1;
            if (!dwelling) yv = ramp_point(corner_y0, slope_y, 1'b0, k);
          end
          2: begin
            yv = corner_y1;
            xv = dwelling ? corner_x1 : ramp_point(corner_x1, slope_x, 1'b1, k);
          end
          default: begin
            yv = dwelling ? corner_y1 : ramp_point(corner_y1, slope_y, 1'b1, k);
          end
        endcase
      end
    end
    last = (frame_len <= 1) || (sample_pos + 1 >= frame_len);
    r.x    = xv[15:0];
    r.y    = yv[15:0];
    r.last = last;
    sample_pos = last ? 0 : ((sample_pos + 1) & 32'hFFFF);
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    mismatches++;
    if (mismatches <= 100)
      $display("%0t mismatch on %s: got %0d, expected %0d", $time, field, got, want);
  endtask

  task automatic check_sample();
    trace_sample_t want;
    if (pending_samples.size() == 0) begin
      report_mismatch("unrequested sample", x_out, -1);
      return;
    end
    want = pending_samples.pop_front();
    if (x_out !== want.x) report_mismatch("x_out", x_out, want.x);
    if (y_out !== want.y) report_mismatch("y_out", y_out, want.y);
    if (frame_last !== want.last) report_mismatch("frame_last", frame_last, want.last);
  endtask

  // receiver: random stalls (none while steady is set), or a counted hold-off when hold_left is set
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) check_sample();
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 13);
      end
    end
  end

  // valid is left high after a request so back-to-back requests need no toggle
  task automatic send_item(input bit rs);
    cfg_valid <= 1'b0;
    if (!steady && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    restart  <= rs;
    do @(posedge clk); while (!in_ready);
    pending_samples.push_back(next_trace_sample(rs));
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_X0:   corner_x0 = val;
      REG_Y0:   corner_y0 = val;
      REG_X1:   corner_x1 = val;
      REG_Y1:   corner_y1 = val;
      REG_FLEN: frame_len = val;
      default: ;
    endcase
  endtask

  task automatic drain_results();
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    do @(posedge clk); while (pending_samples.size() != 0);
  endtask

  task automatic write_corners(input logic [15:0] x0, input logic [15:0] y0,
                               input logic [15:0] x1, input logic [15:0] y1);
    write_reg(REG_X0, x0);
    write_reg(REG_Y0, y0);
    write_reg(REG_X1, x1);
    write_reg(REG_Y1, y1);
  endtask

  function automatic logic [15:0] pick_code();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_frame_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return 16'($urandom_range(3));
    if (r < 75) return 16'($urandom_range(4, 160));
    if (r < 93) return 16'($urandom_range(161, 4000));
    return 16'($urandom_range(4001, 65535));
  endfunction

  // steps are zero out of reset, so ramps stay at their start corner
  task automatic test_flat_before_restart();
    write_reg(REG_FLEN, 16'd8);
    repeat (4) send_item(1'b0);
    drain_results();
  endtask

  task automatic test_full_swing();
    write_corners(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
    send_item(1'b1);
    repeat (7) send_item(1'b0);
    drain_results();
  endtask

  // swap corners without a restart: old steps overshoot both ways
  task automatic test_stale_steps();
    write_corners(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
    repeat (8) send_item(1'b0);
    drain_results();
  endtask

  task automatic test_short_frames();
    write_reg(REG_FLEN, 16'd6);
    send_item(1'b1);
    repeat (5) send_item(1'b0);
    drain_results();
    write_reg(REG_FLEN, 16'd3);
    send_item(1'b1);
    send_item(1'b0);
    drain_results();
    write_reg(REG_FLEN, 16'd1);
    send_item(1'b0);
    drain_results();
    write_reg(REG_FLEN, 16'd0);
    send_item(1'b0);
    drain_results();
    write_reg(3'(REG_FLEN + 1), 16'hA5A5);
    write_reg(3'(REG_FLEN + 3), 16'h5A5A);
    write_reg(REG_FLEN, 16'hFFFF);
    send_item(1'b1);
    send_item(1'b0);
    drain_results();
  endtask

  // output held off long enough that the block stalls its input
  task automatic test_output_backpressure();
    write_corners(16'd1000, 16'd2000, 16'd60000, 16'd50000);
    write_reg(REG_FLEN, 16'd40);
    steady    = 1'b1;
    hold_left = 300;
    send_item(1'b1);
    repeat (15) send_item(1'b0);
    steady = 1'b0;
    drain_results();
  endtask

  task automatic test_random_frames();
    for (int ph = 0; ph < 10; ph++) begin
      steady = (ph == 4);
      write_corners(pick_code(), pick_code(), pick_code(), pick_code());
      write_reg(REG_FLEN, pick_frame_length());
      if ($urandom_range(2) == 0)
        write_reg(3'(REG_FLEN + $urandom_range(1, 3)), pick_code());
      // some phases keep the previous steps
      if ($urandom_range(4) != 0) send_item(1'b1);
      for (int n = 0; n < 100; n++) send_item($urandom_range(99) < 3);
      drain_results();
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_flat_before_restart();
    test_full_swing();
    test_stale_steps();
    test_short_frames();
    test_output_backpressure();
    test_random_frames();
    drain_results();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("[xy_rectangle_trace_gen_top] OK");
    end else begin
      $display("[xy_rectangle_trace_gen_top] ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[xy_rectangle_trace_gen_top] ERROR");
    $finish;
  end

endmodule
